FILE: rtl/rhc_pkg.sv
// shared types and constants for the colour converter
package rhc_pkg;

   localparam int unsigned CompWidth    = 16;
   localparam int unsigned HueWidth     = 15;
   localparam int unsigned FractionBits = 15;
   localparam logic [HueWidth-1:0] HueSector = 15'd3840;
   localparam logic [HueWidth-1:0] HueFull   = 15'd23040;

   typedef enum logic {
      MODE_RGB = 1'b0,
      MODE_HSV = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [CompWidth-1:0]  red;
      logic [CompWidth-1:0]  green;
      logic [CompWidth-1:0]  blue;
      logic [HueWidth-1:0]   hue;
      logic [CompWidth-1:0]  saturation;
      logic [CompWidth-1:0]  brightness;
   } request_type;

   typedef struct packed {
      logic [CompWidth-1:0]  red;
      logic [CompWidth-1:0]  green;
      logic [CompWidth-1:0]  blue;
      logic [HueWidth-1:0]   hue;
      logic [CompWidth-1:0]  saturation;
      logic [CompWidth-1:0]  brightness;
   } colour_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAT_DIV,
      ST_HUE_DIV,
      ST_HSV_MUL,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/rgb_hsv_converter_unit.sv
// top level of the rgb/hsv colour converter
// Keeps one colour in both RGB and HSV form. A request in mode 0 loads RGB and
// derives HSV, mode 1 loads HSV and derives RGB; each request returns all six
// kept values. Requests pass a two-entry queue into a sequencer built around
// one shared restoring divider: an RGB request runs two divisions (one when
// all channels are equal) before its result is on the ports, an HSV request
// a reciprocal multiply for the hue fraction and five multiplies. One
// request is worked at a time; the next is taken the cycle after a pop.
module rgb_hsv_converter_unit
   import rhc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_mode,
   input  logic [CompWidth-1:0] req_red,
   input  logic [CompWidth-1:0] req_green,
   input  logic [CompWidth-1:0] req_blue,
   input  logic [HueWidth-1:0]  req_hue,
   input  logic [CompWidth-1:0] req_saturation,
   input  logic [CompWidth-1:0] req_brightness,
   output logic                 empty,
   input  logic                 pop,
   output logic [CompWidth-1:0] rsp_out_red,
   output logic [CompWidth-1:0] rsp_out_green,
   output logic [CompWidth-1:0] rsp_out_blue,
   output logic [HueWidth-1:0]  rsp_out_hue,
   output logic [CompWidth-1:0] rsp_out_saturation,
   output logic [CompWidth-1:0] rsp_out_brightness
);

   request_type req, q_req;
   colour_type  res;
   logic q_valid, q_take, res_valid;

   always_comb begin
      req.mode = mode_type'(req_mode);
      req.red = req_red;
      req.green = req_green;
      req.blue = req_blue;
      req.hue = req_hue;
      req.saturation = req_saturation;
      req.brightness = req_brightness;
   end

   rhc_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req(req),
      .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
   );

   rhc_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_req(q_req), .res_valid(res_valid), .res_taken(pop), .res(res)
   );

   assign empty = !res_valid;
   assign rsp_out_red = res.red;
   assign rsp_out_green = res.green;
   assign rsp_out_blue = res.blue;
   assign rsp_out_hue = res.hue;
   assign rsp_out_saturation = res.saturation;
   assign rsp_out_brightness = res.brightness;

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_out_hue < HueFull) else $error("hue out of range");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_out_hue)) else $error("result dropped");
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      !empty |-> {1'b0, rsp_out_saturation} <= ((CompWidth+1)'(1) << FractionBits))
      else $error("saturation above one");

endmodule

FILE: rtl/rhc_front.sv
// front end: accepts requests, clamps components and wraps hue into a short queue
module rhc_front
   import rhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  request_type req,
   output logic        q_valid,
   input  logic        q_take,
   output request_type q_req
);

   localparam logic [CompWidth:0] One = (CompWidth+1)'(1) << FractionBits;

   request_type slot_ff [2];
   request_type clean;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       do_push, do_pop;

   function automatic logic [CompWidth-1:0] clamp(input logic [CompWidth-1:0] x);
      if ({1'b0, x} > One) begin
         return One[CompWidth-1:0];
      end
      return x;
   endfunction

   always_comb begin
      clean = req;
      clean.red = clamp(req.red);
      clean.green = clamp(req.green);
      clean.blue = clamp(req.blue);
      clean.saturation = clamp(req.saturation);
      clean.brightness = clamp(req.brightness);
      if (req.hue >= HueFull) begin
         clean.hue = req.hue - HueFull;
      end
   end

   assign full = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_req = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = q_take && q_valid;

   always_comb begin
      count_in = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= clean;
      end
   end

endmodule

FILE: rtl/rhc_divider.sv
// restoring divider, one quotient bit per cycle
module rhc_divider
   import rhc_pkg::*;
#(
   parameter int unsigned NUM_WIDTH = 32,
   parameter int unsigned DEN_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numerator,
   input  logic [DEN_WIDTH-1:0] denominator,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient
);

   localparam int unsigned CntWidth = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [DEN_WIDTH:0]   rem_ff, rem_in, trial;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      quo_in = quo_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DEN_WIDTH-1:0], quo_ff[NUM_WIDTH-1]};
      if (start) begin
         quo_in = numerator;
         den_in = denominator;
         rem_in = '0;
         cnt_in = CntWidth'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/rhc_back.sv
// back end: sequencer that converts one request and keeps the colour state
module rhc_back
   import rhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_take,
   input  request_type q_req,
   output logic        res_valid,
   input  logic        res_taken,
   output colour_type  res
);

   localparam int unsigned NumWidth = 32;
   localparam int unsigned ProdWidth = 2 * CompWidth + 2;
   localparam logic [CompWidth:0] One = (CompWidth+1)'(1) << FractionBits;
   localparam int unsigned ScaledWidth = HueWidth + FractionBits;
   localparam int unsigned SectorShift = 8;
   localparam int unsigned RecipWidth = 20;
   localparam int unsigned RecipShift = 23;
   localparam int unsigned FProdWidth = ScaledWidth - SectorShift + RecipWidth;
   localparam logic [RecipWidth-1:0] RecipFifteen = 20'd559241;

   state_type state_ff, state_in;
   colour_type kept_ff, kept_in;
   request_type cur_ff;
   logic [CompWidth-1:0] mx_ff, d_ff;
   logic [1:0] which_ff;
   logic       neg_ff;
   logic [2:0] step_ff, step_in;
   logic [CompWidth:0] f_ff, fs_ff, gs_ff, p_ff, q_ff, t_ff;
   logic [2:0] sector_ff;
   logic [HueWidth-1:0] rem_ff;

   logic [CompWidth-1:0] mx_c, mn_c, d_c;
   logic [1:0] which_c;
   logic signed [CompWidth:0] diff_c;
   logic [NumWidth-1:0] div_num, div_quo;
   logic [CompWidth-1:0] div_den;
   logic div_start, div_done;
   logic [HueWidth-1:0] hue_mag, hue_fin;
   logic signed [HueWidth+1:0] hue_s;
   logic [2:0] sector_c;
   logic [HueWidth-1:0] rem_c;
   logic [ProdWidth-1:0] prod;
   logic [CompWidth:0] mul_a, mul_b;
   logic [CompWidth:0] f_c;
   logic [ScaledWidth-1:0] f_scaled;
   logic [ScaledWidth-SectorShift-1:0] f_num;
   logic [FProdWidth-1:0] f_prod;

   rhc_divider #(.NUM_WIDTH(NumWidth), .DEN_WIDTH(CompWidth)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numerator(div_num),
      .denominator(div_den), .done(div_done), .quotient(div_quo)
   );

   always_comb begin
      mx_c = q_req.red;
      mn_c = q_req.red;
      if (q_req.green > mx_c) mx_c = q_req.green;
      if (q_req.blue > mx_c) mx_c = q_req.blue;
      if (q_req.green < mn_c) mn_c = q_req.green;
      if (q_req.blue < mn_c) mn_c = q_req.blue;
      d_c = mx_c - mn_c;
      if (mx_c == q_req.red) which_c = 2'd0;
      else if (mx_c == q_req.green) which_c = 2'd1;
      else which_c = 2'd2;
   end

   // hsv sector split, small range so a compare chain is enough
   always_comb begin
      sector_c = 3'd0;
      rem_c = q_req.hue;
      for (int i = 0; i < 5; i++) begin
         if (rem_c >= HueSector) begin
            rem_c = rem_c - HueSector;
            sector_c = sector_c + 3'd1;
         end
      end
   end

   // hue fraction: sector is 15 << 8, so shift then multiply by the reciprocal of 15
   always_comb begin
      f_scaled = {rem_ff, FractionBits'(0)};
      f_num = f_scaled[ScaledWidth-1:SectorShift];
      f_prod = FProdWidth'(f_num) * FProdWidth'(RecipFifteen);
      f_c = f_prod[RecipShift +: CompWidth+1];
   end

   always_comb begin
      case (which_ff)
         2'd0: diff_c = $signed({1'b0, cur_ff.green}) - $signed({1'b0, cur_ff.blue});
         2'd1: diff_c = $signed({1'b0, cur_ff.blue}) - $signed({1'b0, cur_ff.red});
         default: diff_c = $signed({1'b0, cur_ff.red}) - $signed({1'b0, cur_ff.green});
      endcase
   end

   always_comb begin
      q_take = (state_ff == ST_IDLE) && q_valid;
      div_start = 1'b0;
      div_num = '0;
      div_den = '1;
      if (q_take && q_req.mode == MODE_RGB) begin
         div_start = 1'b1;
         div_num = NumWidth'({d_c, FractionBits'(0)});
         div_den = (mx_c == '0) ? CompWidth'(1) : mx_c;
      end else if (state_ff == ST_SAT_DIV && div_done) begin
         div_start = 1'b1;
         div_num = NumWidth'(diff_c[CompWidth] ? -diff_c : diff_c) * NumWidth'(HueSector);
         div_den = (d_ff == '0) ? CompWidth'(1) : d_ff;
      end
   end

   always_comb begin
      hue_mag = div_quo[HueWidth-1:0];
      case (which_ff)
         2'd0: hue_s = 17'sd0;
         2'd1: hue_s = 17'sd7680;
         default: hue_s = 17'sd15360;
      endcase
      hue_s = neg_ff ? hue_s - $signed({2'b0, hue_mag}) : hue_s + $signed({2'b0, hue_mag});
      if (hue_s < 0) hue_s = hue_s + $signed({2'b0, HueFull});
      hue_fin = hue_s[HueWidth-1:0];
   end

   always_comb begin
      case (step_ff)
         3'd0: begin mul_a = f_ff; mul_b = {1'b0, cur_ff.saturation}; end
         3'd1: begin mul_a = One - f_ff; mul_b = {1'b0, cur_ff.saturation}; end
         3'd2: begin mul_a = {1'b0, cur_ff.brightness}; mul_b = One - cur_ff.saturation; end
         3'd3: begin mul_a = {1'b0, cur_ff.brightness}; mul_b = One - fs_ff; end
         default: begin mul_a = {1'b0, cur_ff.brightness}; mul_b = One - gs_ff; end
      endcase
      prod = ProdWidth'(mul_a) * ProdWidth'(mul_b);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_take) state_in = (q_req.mode == MODE_RGB) ? ST_SAT_DIV : ST_HSV_MUL;
         ST_SAT_DIV: if (div_done) state_in = (d_ff == '0) ? ST_DONE : ST_HUE_DIV;
         ST_HUE_DIV: if (div_done) state_in = ST_DONE;
         ST_HSV_MUL: if (step_ff == 3'd5) state_in = ST_DONE;
         ST_DONE: if (res_taken) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      kept_in = kept_ff;
      step_in = step_ff;
      if (q_take && q_req.mode == MODE_RGB) begin
         kept_in.red = q_req.red;
         kept_in.green = q_req.green;
         kept_in.blue = q_req.blue;
         kept_in.brightness = mx_c;
      end else if (q_take) begin
         kept_in.hue = q_req.hue;
         kept_in.saturation = q_req.saturation;
         kept_in.brightness = q_req.brightness;
         step_in = 3'd7;
      end
      if (state_ff == ST_SAT_DIV && div_done && mx_ff != '0) begin
         kept_in.saturation = div_quo[CompWidth-1:0];
      end
      if (state_ff == ST_HUE_DIV && div_done) begin
         kept_in.hue = hue_fin;
      end
      if (state_ff == ST_HSV_MUL) begin
         // step 7 loads the hue fraction and wraps round to step 0
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd5) begin
            case (sector_ff)
               3'd0: begin kept_in.red = cur_ff.brightness; kept_in.green = t_ff[CompWidth-1:0]; kept_in.blue = p_ff[CompWidth-1:0]; end
               3'd1: begin kept_in.red = q_ff[CompWidth-1:0]; kept_in.green = cur_ff.brightness; kept_in.blue = p_ff[CompWidth-1:0]; end
               3'd2: begin kept_in.red = p_ff[CompWidth-1:0]; kept_in.green = cur_ff.brightness; kept_in.blue = t_ff[CompWidth-1:0]; end
               3'd3: begin kept_in.red = p_ff[CompWidth-1:0]; kept_in.green = q_ff[CompWidth-1:0]; kept_in.blue = cur_ff.brightness; end
               3'd4: begin kept_in.red = t_ff[CompWidth-1:0]; kept_in.green = p_ff[CompWidth-1:0]; kept_in.blue = cur_ff.brightness; end
               default: begin kept_in.red = cur_ff.brightness; kept_in.green = p_ff[CompWidth-1:0]; kept_in.blue = q_ff[CompWidth-1:0]; end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kept_ff <= '0;
         step_ff <= 3'd7;
      end else begin
         state_ff <= state_in;
         kept_ff <= kept_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) begin
         cur_ff <= q_req;
         mx_ff <= mx_c;
         d_ff <= d_c;
         which_ff <= which_c;
         sector_ff <= sector_c;
         rem_ff <= rem_c;
      end
      if (state_ff == ST_SAT_DIV) begin
         neg_ff <= diff_c[CompWidth];
      end
      if (state_ff == ST_HSV_MUL) begin
         if (step_ff == 3'd7) f_ff <= f_c;
         case (step_ff)
            3'd0: fs_ff <= prod[FractionBits +: CompWidth+1];
            3'd1: gs_ff <= prod[FractionBits +: CompWidth+1];
            3'd2: p_ff <= prod[FractionBits +: CompWidth+1];
            3'd3: q_ff <= prod[FractionBits +: CompWidth+1];
            3'd4: t_ff <= prod[FractionBits +: CompWidth+1];
            default: ;
         endcase
      end
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res = kept_ff;

endmodule
